// ===== sv/mqttpd_pkg.sv =====
// Shared types and constants for the publish-packet deframer.
package mqttpd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN_LO,
		PH_HEADER,
		PH_VARINT,
		PH_TOPIC_HI,
		PH_TOPIC_LO,
		PH_SKIP,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_VARINT_LONG,
		ST_TOPIC_LONG,
		ST_CUT_SHORT
	} status_t;

	localparam int RecLenW = 16;
	localparam int PktLenW = 28;
	localparam int ByteW   = 8;

	typedef struct packed {
		logic               valid;
		logic [ByteW-1:0]   cmd_byte;
		logic               last_of_command;
		logic               empty_command;
		status_t            status;
	} result_t;

endpackage

// ===== sv/mqttpd_parser.sv =====
// Parser state and the single-pass next-state and result logic for one byte.
module mqttpd_parser #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  logic [mqttpd_pkg::ByteW-1:0] data_byte,
	input  logic                         record_start,
	output mqttpd_pkg::result_t          result
);

	mqttpd_pkg::phase_t              phase_q, phase_d;
	logic [mqttpd_pkg::RecLenW-1:0]  record_left_q, record_left_d, rl_dec;
	logic [mqttpd_pkg::PktLenW-1:0]  remaining_length_q, remaining_length_d;
	logic [1:0]                      varint_count_q, varint_count_d;
	logic [mqttpd_pkg::RecLenW-1:0]  topic_left_q, topic_left_d, topic_dec, topic_word;
	logic [mqttpd_pkg::PktLenW-1:0]  payload_left_q, payload_left_d, payload_dec;
	logic [mqttpd_pkg::ByteW-1:0]    held_high_byte_q, held_high_byte_d;
	logic [mqttpd_pkg::PktLenW-1:0]  varint_part, varint_acc, rem_minus2;
	logic [2:0]                      varint_next;
	mqttpd_pkg::status_t             err;
	logic                            done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= mqttpd_pkg::PH_IDLE;
			record_left_q      <= '0;
			remaining_length_q <= '0;
			varint_count_q     <= '0;
			topic_left_q       <= '0;
			payload_left_q     <= '0;
			held_high_byte_q   <= '0;
		end else if (step_en) begin
			phase_q            <= phase_d;
			record_left_q      <= record_left_d;
			remaining_length_q <= remaining_length_d;
			varint_count_q     <= varint_count_d;
			topic_left_q       <= topic_left_d;
			payload_left_q     <= payload_left_d;
			held_high_byte_q   <= held_high_byte_d;
		end
	end

	always_comb begin
		unique case (varint_count_q)
			2'd0: varint_part = {21'b0, data_byte[6:0]};
			2'd1: varint_part = {14'b0, data_byte[6:0], 7'b0};
			2'd2: varint_part = {7'b0, data_byte[6:0], 14'b0};
			default: varint_part = {data_byte[6:0], 21'b0};
		endcase
	end

	assign varint_acc  = remaining_length_q | varint_part;
	assign varint_next = {1'b0, varint_count_q} + 3'd1;
	assign rl_dec      = record_left_q - 16'd1;
	assign topic_dec   = topic_left_q - 16'd1;
	assign payload_dec = payload_left_q - 28'd1;
	assign topic_word  = {held_high_byte_q, data_byte};
	assign rem_minus2  = remaining_length_q - 28'd2;

	always_comb begin
		phase_d            = phase_q;
		record_left_d      = record_left_q;
		remaining_length_d = remaining_length_q;
		varint_count_d     = varint_count_q;
		topic_left_d       = topic_left_q;
		payload_left_d     = payload_left_q;
		held_high_byte_d   = held_high_byte_q;
		result             = '0;
		err                = mqttpd_pkg::ST_OK;
		done               = 1'b0;
		priority if (record_start) begin
			if (phase_q != mqttpd_pkg::PH_IDLE && phase_q != mqttpd_pkg::PH_LEN_LO) begin
				result.valid  = 1'b1;
				result.status = mqttpd_pkg::ST_CUT_SHORT;
			end
			held_high_byte_d = data_byte;
			phase_d          = mqttpd_pkg::PH_LEN_LO;
		end else if (phase_q == mqttpd_pkg::PH_IDLE) begin
			phase_d = mqttpd_pkg::PH_IDLE;
		end else if (phase_q == mqttpd_pkg::PH_LEN_LO) begin
			record_left_d = {held_high_byte_q, data_byte};
			phase_d = (record_left_d != '0) ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_IDLE;
		end else begin
			record_left_d = rl_dec;
			unique case (phase_q)
				mqttpd_pkg::PH_HEADER: begin
					remaining_length_d = '0;
					varint_count_d     = '0;
					phase_d            = mqttpd_pkg::PH_VARINT;
				end
				mqttpd_pkg::PH_VARINT: begin
					remaining_length_d = varint_acc;
					if (data_byte[7]) begin
						if (varint_next >= 3'(MAX_LENGTH_BYTES))
							err = mqttpd_pkg::ST_VARINT_LONG;
						else
							varint_count_d = varint_next[1:0];
					end else if (varint_acc < 28'd2) begin
						err = mqttpd_pkg::ST_TOPIC_LONG;
					end else begin
						phase_d = mqttpd_pkg::PH_TOPIC_HI;
					end
				end
				mqttpd_pkg::PH_TOPIC_HI: begin
					held_high_byte_d = data_byte;
					phase_d          = mqttpd_pkg::PH_TOPIC_LO;
				end
				mqttpd_pkg::PH_TOPIC_LO: begin
					topic_left_d = topic_word;
					if ({12'b0, topic_word} > rem_minus2) begin
						err = mqttpd_pkg::ST_TOPIC_LONG;
					end else begin
						payload_left_d = rem_minus2 - {12'b0, topic_word};
						if (topic_word != '0) begin
							phase_d = mqttpd_pkg::PH_SKIP;
						end else if (payload_left_d != '0) begin
							phase_d = mqttpd_pkg::PH_PAYLOAD;
						end else begin
							result.valid           = 1'b1;
							result.last_of_command = 1'b1;
							result.empty_command   = 1'b1;
							done                   = 1'b1;
						end
					end
				end
				mqttpd_pkg::PH_SKIP: begin
					topic_left_d = topic_dec;
					if (topic_dec == '0) begin
						if (payload_left_q != '0) begin
							phase_d = mqttpd_pkg::PH_PAYLOAD;
						end else begin
							result.valid           = 1'b1;
							result.last_of_command = 1'b1;
							result.empty_command   = 1'b1;
							done                   = 1'b1;
						end
					end
				end
				default: begin
					payload_left_d         = payload_dec;
					result.valid           = 1'b1;
					result.cmd_byte        = data_byte;
					result.last_of_command = (payload_dec == '0);
					done                   = (payload_dec == '0);
				end
			endcase
			priority if (err != mqttpd_pkg::ST_OK) begin
				result        = '0;
				result.valid  = 1'b1;
				result.status = err;
				phase_d       = mqttpd_pkg::PH_IDLE;
			end else if (done) begin
				phase_d = (rl_dec != '0) ? mqttpd_pkg::PH_HEADER : mqttpd_pkg::PH_IDLE;
			end else if (rl_dec == '0) begin
				result        = '0;
				result.valid  = 1'b1;
				result.status = mqttpd_pkg::ST_CUT_SHORT;
				phase_d       = mqttpd_pkg::PH_IDLE;
			end else begin
				phase_d = phase_d;
			end
		end
	end

	a_error_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !record_start && result.valid && result.status != mqttpd_pkg::ST_OK
		|=> phase_q == mqttpd_pkg::PH_IDLE)
		else $error("Parser did not drop the record after an error.");

	a_varint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mqttpd_pkg::PH_VARINT |-> {1'b0, varint_count_q} < 3'(MAX_LENGTH_BYTES))
		else $error("Length field byte count ran past its limit.");

	a_start_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && record_start |=> phase_q == mqttpd_pkg::PH_LEN_LO
		&& held_high_byte_q == $past(data_byte))
		else $error("Record start did not reload the length prefix.");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mqttpd_pkg::PH_PAYLOAD |-> payload_left_q != '0)
		else $error("Payload phase entered with nothing left to send.");

endmodule

// ===== sv/mqtt_publish_deframer.sv =====
// Top level of the publish-packet deframer: input register, parser and result register.
//
//  Channel  Direction  tdata                 tuser                        tlast
//  s_*      in         [7:0] data_byte       [0] record_start             -
//  m_*      out        [7:0] cmd_byte        [0] empty_command,           last_of_command
//                                            [2:1] status
//
// A new word is accepted every cycle while the result register drains. The input register
// and the result register sit around the parser logic. The asynchronous reset puts the
// parser back to waiting for a record start. When m_tready is low with a result held, the
// input register stalls and s_tready drops once it is full.
module mqtt_publish_deframer #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic [0:0] s_tuser,  // [0] record_start
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] cmd_byte
	output logic [2:0] m_tuser,  // [0] empty_command, [2:1] status
	output logic       m_tlast
);

	logic                 valid_s1, valid_s2, adv;
	logic [7:0]           data_s1;
	logic                 start_s1;
	mqttpd_pkg::result_t  res;
	mqttpd_pkg::result_t  res_s2;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= res.valid;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
		if (adv && res.valid)
			res_s2 <= res;
	end

	mqttpd_parser #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (adv),
		.data_byte   (data_s1),
		.record_start(start_s1),
		.result      (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.cmd_byte;
	assign m_tlast  = res_s2.last_of_command;
	assign m_tuser  = {res_s2.status, res_s2.empty_command};

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(data_s1) && $stable(start_s1))
		else $error("Input register changed while stalled.");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.empty_command |-> res_s2.last_of_command
		&& res_s2.status == mqttpd_pkg::ST_OK)
		else $error("Empty command result is malformed.");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.status != mqttpd_pkg::ST_OK |-> !res_s2.last_of_command
		&& !res_s2.empty_command && res_s2.cmd_byte == '0)
		else $error("Status result carries command fields.");

endmodule
